// File: rtl/rmth_pkg.sv
// Package for the running median block: sizes, state encoding and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none
package rmth_pkg;
    localparam int Capacity   = 1024;
    localparam int HeapDepth  = (Capacity + 1) / 2;
    localparam int AddrW      = $clog2(HeapDepth);
    localparam int CntW       = $clog2(HeapDepth + 1);
    localparam int HeldW      = 11;
    localparam int DataW      = 32;
    localparam int MedW       = 33;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_POP_START,
        ST_POP_READ,
        ST_POP_STEP,
        ST_PUSH_START,
        ST_PUSH_READ,
        ST_PUSH_STEP,
        ST_RESULT,
        ST_OUT
    } state_t;

    // Which push comes next in the job sequence.
    typedef enum logic [1:0] {
        JOB_NONE,
        JOB_PUSH_SAMPLE,
        JOB_PUSH_MOVED
    } job_t;

    typedef struct packed {
        logic load_sample;   // capture input sample
        logic pop_start;     // begin pop on heap sel
        logic pop_read;      // issue child reads
        logic pop_step;      // compare children and move
        logic push_start;    // begin push
        logic push_read;     // issue parent read
        logic push_step;     // compare parent and move
        logic heap_sel;      // 0 lower (max), 1 upper (min)
        logic push_moved;    // push the popped top instead of the sample
        logic make_result;   // register median and count
    } cmd_t;

    typedef struct packed {
        logic full;
        logic lower_empty;
        logic counts_equal;
        logic lower_larger;
        logic below_lower_top;
        logic above_lower_top;
        logic below_upper_top;
        logic step_done;     // current sift finished
        logic pop_trivial;   // popped heap became empty
    } stat_t;
endpackage
`default_nettype wire

// File: rtl/rmth_ctrl.sv
// Controller state machine for the running median block.
// Depends on rmth_pkg for state and command types.
`default_nettype none
module rmth_ctrl
    import rmth_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_fire,
    input  wire logic  out_free,
    input  wire stat_t stat,
    output cmd_t       cmd,
    output logic       busy,
    output logic       result_valid
);
    state_t state_reg, state_next;
    logic   sel_reg, sel_next;
    job_t   job_reg, job_next;
    logic   moved_reg, moved_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= 1'b0;
            job_reg   <= JOB_NONE;
            moved_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            job_reg   <= job_next;
            moved_reg <= moved_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        sel_next     = sel_reg;
        job_next     = job_reg;
        moved_next   = moved_reg;
        cmd          = '0;
        cmd.heap_sel = sel_reg;
        cmd.push_moved = moved_reg;
        busy         = 1'b1;
        result_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                cmd.load_sample = in_fire;
                if (in_fire)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                moved_next = 1'b0;
                job_next   = JOB_NONE;
                if (stat.full)
                    state_next = ST_RESULT;
                else if (stat.lower_empty)
                begin
                    sel_next = 1'b0;
                    state_next = ST_PUSH_START;
                end
                else if (stat.counts_equal)
                begin
                    sel_next = stat.below_lower_top ? 1'b0 : 1'b1;
                    state_next = ST_PUSH_START;
                end
                else if (stat.lower_larger)
                begin
                    if (stat.above_lower_top)
                    begin
                        sel_next = 1'b1;
                        state_next = ST_PUSH_START;
                    end
                    else
                    begin
                        sel_next = 1'b0;
                        job_next = JOB_PUSH_MOVED;
                        state_next = ST_POP_START;
                    end
                end
                else
                begin
                    if (stat.below_upper_top)
                    begin
                        sel_next = 1'b0;
                        state_next = ST_PUSH_START;
                    end
                    else
                    begin
                        sel_next = 1'b1;
                        job_next = JOB_PUSH_MOVED;
                        state_next = ST_POP_START;
                    end
                end
            end
            ST_POP_START:
            begin
                cmd.pop_start = 1'b1;
                state_next = stat.pop_trivial ? ST_PUSH_START : ST_POP_READ;
                if (stat.pop_trivial)
                begin
                    sel_next   = ~sel_reg;
                    moved_next = 1'b1;
                end
            end
            ST_POP_READ:
            begin
                cmd.pop_read = 1'b1;
                state_next = ST_POP_STEP;
            end
            ST_POP_STEP:
            begin
                cmd.pop_step = 1'b1;
                if (stat.step_done)
                begin
                    sel_next   = ~sel_reg;
                    moved_next = 1'b1;
                    state_next = ST_PUSH_START;
                end
                else
                    state_next = ST_POP_READ;
            end
            ST_PUSH_START:
            begin
                cmd.push_start = 1'b1;
                state_next = ST_PUSH_READ;
            end
            ST_PUSH_READ:
            begin
                cmd.push_read = 1'b1;
                state_next = ST_PUSH_STEP;
            end
            ST_PUSH_STEP:
            begin
                cmd.push_step = 1'b1;
                if (stat.step_done)
                begin
                    if (job_reg == JOB_PUSH_MOVED)
                    begin
                        job_next   = JOB_PUSH_SAMPLE;
                        sel_next   = ~sel_reg;
                        moved_next = 1'b0;
                        state_next = ST_PUSH_START;
                    end
                    else
                        state_next = ST_RESULT;
                end
                else
                    state_next = ST_PUSH_READ;
            end
            ST_RESULT:
            begin
                cmd.make_result = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                result_valid = 1'b1;
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// File: rtl/rmth_datapath.sv
// Datapath for the running median block: the two heap memories, counts,
// sift registers and the result register. Depends on rmth_pkg.
`default_nettype none
module rmth_datapath
    import rmth_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmd_t              cmd,
    input  wire logic [DataW-1:0]  sample,
    output stat_t                  stat,
    output logic signed [MedW-1:0] median_doubled,
    output logic [HeldW-1:0]       held_count,
    output logic                   overflow
);
    // Each heap is a memory; the tops are mirrored in registers so the
    // median and decisions never wait for a read.
    logic [DataW-1:0] lower_mem [HeapDepth];
    logic [DataW-1:0] upper_mem [HeapDepth];
    logic [DataW-1:0] lo_rd_a_reg, lo_rd_b_reg, up_rd_a_reg, up_rd_b_reg;
    logic signed [DataW-1:0] lower_top_reg, upper_top_reg;
    logic [CntW-1:0] lower_cnt_reg, upper_cnt_reg;
    logic signed [DataW-1:0] sample_reg, moved_reg, val_reg;
    logic [CntW-1:0] idx_reg, n_reg;
    logic fetch_reg;
    logic signed [MedW-1:0] med_reg;
    logic [HeldW-1:0] held_reg;
    logic ovf_reg;

    logic sel;
    logic [CntW-1:0] cnt_sel, child_l, child_r, parent, last_idx;
    logic [AddrW-1:0] rd_a, rd_b, wr_addr;
    logic wr_en;
    logic [DataW-1:0] wr_data;
    logic signed [DataW-1:0] ca, cb, best;
    logic [CntW-1:0] best_idx;
    logic move;
    logic [HeldW-1:0] total;

    assign sel      = cmd.heap_sel;
    assign cnt_sel  = sel ? upper_cnt_reg : lower_cnt_reg;
    assign last_idx = cnt_sel - CntW'(1);
    assign child_l  = {idx_reg[CntW-2:0], 1'b1};
    assign child_r  = child_l + CntW'(1);
    assign parent   = (idx_reg - CntW'(1)) >> 1;
    assign total    = HeldW'(lower_cnt_reg) + HeldW'(upper_cnt_reg);

    // before(a,b): a sits above b in the selected heap.
    function automatic logic before_f(input logic s, input logic signed [DataW-1:0] a,
                                      input logic signed [DataW-1:0] b);
        before_f = s ? (a < b) : (a > b);
    endfunction

    always_comb
    begin
        rd_a = cmd.push_read ? parent[AddrW-1:0] : child_l[AddrW-1:0];
        // At the start of a pop the second port fetches the last entry.
        rd_b = cmd.pop_start ? last_idx[AddrW-1:0] : child_r[AddrW-1:0];
        ca = sel ? signed'(up_rd_a_reg) : signed'(lo_rd_a_reg);
        cb = sel ? signed'(up_rd_b_reg) : signed'(lo_rd_b_reg);
        best = ca;
        best_idx = child_l;
        if (child_r < n_reg && before_f(sel, cb, ca))
        begin
            best = cb;
            best_idx = child_r;
        end
        move = 1'b0;
        wr_en = 1'b0;
        wr_addr = idx_reg[AddrW-1:0];
        wr_data = val_reg;
        if (cmd.pop_step)
        begin
            move = (child_l < n_reg) && before_f(sel, best, val_reg);
            wr_en = 1'b1;
            wr_data = move ? best : val_reg;
        end
        else if (cmd.push_step)
        begin
            move = (idx_reg != '0) && before_f(sel, val_reg, ca);
            wr_en = 1'b1;
            wr_data = move ? ca : val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && !sel)
            lower_mem[wr_addr] <= wr_data;
        if (wr_en && sel)
            upper_mem[wr_addr] <= wr_data;
        lo_rd_a_reg <= lower_mem[rd_a];
        lo_rd_b_reg <= lower_mem[rd_b];
        up_rd_a_reg <= upper_mem[rd_a];
        up_rd_b_reg <= upper_mem[rd_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_cnt_reg <= '0;
            upper_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.pop_start)
            begin
                if (sel)
                    upper_cnt_reg <= upper_cnt_reg - CntW'(1);
                else
                    lower_cnt_reg <= lower_cnt_reg - CntW'(1);
            end
            if (cmd.push_start)
            begin
                if (sel)
                    upper_cnt_reg <= upper_cnt_reg + CntW'(1);
                else
                    lower_cnt_reg <= lower_cnt_reg + CntW'(1);
            end
        end
    end

    // Sift registers and top mirrors.
    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
            sample_reg <= signed'(sample);
        if (cmd.pop_start)
        begin
            moved_reg <= sel ? upper_top_reg : lower_top_reg;
            n_reg     <= cnt_sel - CntW'(1);
            idx_reg   <= '0;
        end
        if (cmd.push_start)
        begin
            val_reg <= cmd.push_moved ? moved_reg : sample_reg;
            idx_reg <= cnt_sel;
        end
        // The last entry, read at the start of the pop, becomes the
        // sifting value.
        if (cmd.pop_read && fetch_reg)
            val_reg <= sel ? signed'(up_rd_b_reg) : signed'(lo_rd_b_reg);
        if (cmd.pop_step && move)
            idx_reg <= best_idx;
        if (cmd.push_step && move)
            idx_reg <= parent;
        if (wr_en && wr_addr == '0 && idx_reg == '0)
        begin
            if (sel)
                upper_top_reg <= wr_data;
            else
                lower_top_reg <= wr_data;
        end
        else if (cmd.pop_step && move && idx_reg == '0)
        begin
            if (sel)
                upper_top_reg <= best;
            else
                lower_top_reg <= best;
        end
        else if (cmd.push_step && move && parent == '0)
        begin
            if (sel)
                upper_top_reg <= val_reg;
            else
                lower_top_reg <= val_reg;
        end
        if (cmd.make_result)
        begin
            held_reg <= total;
            if (lower_cnt_reg == upper_cnt_reg)
                med_reg <= ((lower_cnt_reg != '0) ? MedW'(lower_top_reg) : '0)
                         + ((upper_cnt_reg != '0) ? MedW'(upper_top_reg) : '0);
            else if (lower_cnt_reg > upper_cnt_reg)
                med_reg <= MedW'(lower_top_reg) <<< 1;
            else
                med_reg <= MedW'(upper_top_reg) <<< 1;
        end
    end

    // The fetch flag marks the first read phase of a pop. Overflow is the
    // full verdict taken when the sample is accepted, before any insert.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fetch_reg <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.pop_start)
                fetch_reg <= 1'b1;
            else if (cmd.pop_read)
                fetch_reg <= 1'b0;
            if (cmd.load_sample)
                ovf_reg <= total >= HeldW'(Capacity);
        end
    end

    always_comb
    begin
        stat.full            = total >= HeldW'(Capacity);
        stat.lower_empty     = lower_cnt_reg == '0;
        stat.counts_equal    = lower_cnt_reg == upper_cnt_reg;
        stat.lower_larger    = lower_cnt_reg > upper_cnt_reg;
        stat.below_lower_top = sample_reg < lower_top_reg;
        stat.above_lower_top = sample_reg > lower_top_reg;
        stat.below_upper_top = sample_reg < upper_top_reg;
        stat.pop_trivial     = cnt_sel == CntW'(1);
        stat.step_done       = !move;
    end

    assign median_doubled = med_reg;
    assign held_count     = held_reg;
    assign overflow       = ovf_reg;
endmodule
`default_nettype wire

// File: rtl/running_median_two_heaps.sv
// Running median over two heaps. Each input word carries one signed 32-bit
// sample; each output word returns twice the median of all held samples, the
// held count and an overflow flag. The lower half lives in a max-heap and the
// upper half in a min-heap, each in its own 512-entry memory with the top
// mirrored in a register. An item accepted while the store is full goes
// straight from the decide state to the result; otherwise it is inserted by
// a push, or by a pop plus two pushes: a pop sifts down and a push sifts up,
// each level taking one memory read and then one compare and write, after a
// start state for each, with a decide state first and a result state last.
// One item is processed at a time; the next input word is taken once the
// result word has been taken. No clearing pass is needed after reset.
// Depends on rmth_pkg, rmth_ctrl and rmth_datapath.
`default_nettype none
module running_median_two_heaps
    import rmth_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] sample
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata    // [32:0] median_doubled, [43:33] held_count,
                                        // [44] overflow, [47:45] zero
);
    cmd_t  cmd;
    stat_t stat;
    logic  busy;
    logic  result_valid;
    logic signed [MedW-1:0] med;
    logic [HeldW-1:0] held;
    logic ovf;

    assign s_tready = !busy;
    assign m_tvalid = result_valid;
    assign m_tdata  = {3'b000, ovf, held, med};

    rmth_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_fire      (s_tvalid && !busy),
        .out_free     (m_tready),
        .stat         (stat),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid)
    );

    rmth_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sample         (s_tdata),
        .stat           (stat),
        .median_doubled (med),
        .held_count     (held),
        .overflow       (ovf)
    );
endmodule
`default_nettype wire

// File: rtl/rmth_checker.sv
// Port checker for the running median block, bound to the top level.
// Depends on the top level's ports only.
`default_nettype none
module rmth_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(m_tvalid && s_tready))
        else $error("input taken while result pending");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[43:33] <= 11'd1024)
        else $error("held count beyond capacity");
    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[44] |-> m_tdata[43:33] == 11'd1024)
        else $error("overflow below capacity");
endmodule

bind running_median_two_heaps rmth_checker u_rmth_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
